// File: hw/rtl/lbfv_pkg.sv
// lbfv_pkg: shared types and fixed-point constants for the lorentz boost core
// no dependencies; used by the channel interfaces and the core
package lbfv_pkg;

   localparam int DATA_WIDTH     = 32;
   localparam int DATA_FRAC_BITS = 16;
   localparam int BETA_FRAC_BITS = 30;

   // shift from the exact p.b sum down to the Q32 dot product
   localparam int PB_SHIFT = BETA_FRAC_BITS - DATA_FRAC_BITS;
   localparam int K_SHIFT  = BETA_FRAC_BITS + DATA_FRAC_BITS;
   localparam int SQ_PRE   = 64 - 2 * BETA_FRAC_BITS;
   localparam int PB_W     = 66 - PB_SHIFT;

   localparam logic [63:0] ONE_B2   = 64'd1 << (2 * BETA_FRAC_BITS);
   localparam logic [63:0] ONE_BETA = 64'd1 << BETA_FRAC_BITS;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   // per-item values that ride along the pipeline
   typedef struct packed {
      data_type              px;
      data_type              py;
      data_type              pz;
      data_type              energy;
      data_type              bx;
      data_type              by;
      data_type              bz;
      logic signed [PB_W-1:0] pb32;
      logic                  pass;
   } item_type;

endpackage

// File: hw/rtl/lbfv_if.sv
// lbfv_req_if / lbfv_rsp_if: valid-ready channels for four-vectors and boost results
// depends on lbfv_pkg
interface lbfv_req_if import lbfv_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type px_in;
   data_type py_in;
   data_type pz_in;
   data_type energy_in;
   data_type beta_x;
   data_type beta_y;
   data_type beta_z;

   modport source (output valid, px_in, py_in, pz_in, energy_in, beta_x, beta_y, beta_z,
                   input ready);
   modport sink   (input valid, px_in, py_in, pz_in, energy_in, beta_x, beta_y, beta_z,
                   output ready);
endinterface

interface lbfv_rsp_if import lbfv_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type px_out;
   data_type py_out;
   data_type pz_out;
   data_type energy_out;
   logic     passed_through;
   logic     saturated;

   modport source (output valid, px_out, py_out, pz_out, energy_out, passed_through,
                   saturated, input ready);
   modport sink   (input valid, px_out, py_out, pz_out, energy_out, passed_through,
                   saturated, output ready);
endinterface

// File: hw/rtl/lorentz_boost_four_vector_core.sv
// throughput: one item per cycle while rsp_chan.ready holds; the depth is set by the bit-per-stage square root
//   (32 stages) and the two restoring dividers (61 and 30 stages)
// each stage holds its item until the next one frees up, so bubbles close up on a stall
// reset: synchronous, clears the stage valid bits only; datapath registers are not reset
module lorentz_boost_four_vector_core import lbfv_pkg::*; (
   input  logic clock,
   input  logic reset,
   lbfv_req_if.sink   req_chan,
   lbfv_rsp_if.source rsp_chan
);

   localparam int SQ_STEPS = 32;
   localparam int GD_STEPS = 61;
   localparam int FD_STEPS = 30;

   localparam int ST_PRE  = 0;
   localparam int ST_SUM  = 1;
   localparam int ST_PREP = 2;
   localparam int ST_SQ0  = 3;
   localparam int ST_GD0  = ST_SQ0 + SQ_STEPS;
   localparam int ST_GX   = ST_GD0 + GD_STEPS;
   localparam int ST_FD0  = ST_GX + 1;
   localparam int ST_FX   = ST_FD0 + FD_STEPS;
   localparam int ST_M1   = ST_FX + 1;
   localparam int ST_M2   = ST_M1 + 1;
   localparam int ST_M3   = ST_M2 + 1;
   localparam int ST_M4   = ST_M3 + 1;
   localparam int ST_M5   = ST_M4 + 1;
   localparam int ST_M6   = ST_M5 + 1;
   localparam int ST_M7   = ST_M6 + 1;
   localparam int ST_OUT  = ST_M7 + 1;
   localparam int NST     = ST_OUT + 1;

   // sq is at least 4 for a real boost, so the top two quotient bits of 2^62/sq are zero
   localparam logic [31:0] GD_REM_INIT = 32'd2;
   localparam logic signed [115:0] K_HI = 116'(64'h4000_0000_0000_0000);
   localparam logic signed [115:0] K_LO = -K_HI;

   typedef struct packed {
      data_type px;
      data_type py;
      data_type pz;
      data_type energy;
      logic     pass;
      logic     sat;
   } res_type;

   function automatic logic signed [63:0] smul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic signed [65:0] p;
      p = a * b;
      return 64'(p);
   endfunction

   function automatic logic signed [32:0] uz33(input logic [31:0] u);
      return $signed({1'b0, u});
   endfunction

   // {clip, value}
   function automatic logic [32:0] clamp32(input logic signed [127:0] v);
      if ((&v[127:31]) || !(|v[127:31])) begin
         return {1'b0, v[31:0]};
      end else if (v[127]) begin
         return {1'b1, 32'h8000_0000};
      end else begin
         return {1'b1, 32'h7fff_ffff};
      end
   endfunction

   // ---------------------------------------------------------------- flow control
   logic     v_ff [NST];
   logic     en   [NST];
   item_type base_ff [ST_OUT];

   genvar k;
   generate
      for (k = 0; k < NST; k++) begin : g_ctl
         if (k == NST - 1) begin : g_last
            assign en[k] = !v_ff[k] || rsp_chan.ready;
         end else begin : g_mid
            assign en[k] = !v_ff[k] || en[k+1];
         end
         if (k == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (reset) begin
                  v_ff[k] <= 1'b0;
               end else if (en[k]) begin
                  v_ff[k] <= req_chan.valid;
               end
            end
         end else begin : g_rest
            always_ff @(posedge clock) begin
               if (reset) begin
                  v_ff[k] <= 1'b0;
               end else if (en[k]) begin
                  v_ff[k] <= v_ff[k-1];
               end
            end
         end
      end
   endgenerate

   assign req_chan.ready = en[0];

   // ---------------------------------------------------------------- squares and p.b
   logic signed [63:0] bsq_ff [3];
   logic signed [63:0] pbp_ff [3];

   always_ff @(posedge clock) begin
      if (en[ST_PRE]) begin
         bsq_ff[0] <= smul(33'(req_chan.beta_x), 33'(req_chan.beta_x));
         bsq_ff[1] <= smul(33'(req_chan.beta_y), 33'(req_chan.beta_y));
         bsq_ff[2] <= smul(33'(req_chan.beta_z), 33'(req_chan.beta_z));
         pbp_ff[0] <= smul(33'(req_chan.px_in), 33'(req_chan.beta_x));
         pbp_ff[1] <= smul(33'(req_chan.py_in), 33'(req_chan.beta_y));
         pbp_ff[2] <= smul(33'(req_chan.pz_in), 33'(req_chan.beta_z));
      end
   end

   logic [63:0]        beta2_ff;
   logic signed [65:0] pb_sum;
   logic signed [PB_W-1:0] pb32_sum;

   assign pb_sum   = 66'(pbp_ff[0]) + 66'(pbp_ff[1]) + 66'(pbp_ff[2]);
   assign pb32_sum = PB_W'(pb_sum >>> PB_SHIFT);

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         beta2_ff <= $unsigned(bsq_ff[0]) + $unsigned(bsq_ff[1]) + $unsigned(bsq_ff[2]);
      end
   end

   logic        pass_s2;
   logic [63:0] sqx_ff;

   // zero boost or beta2 at or past one goes straight through
   assign pass_s2 = (beta2_ff == 64'd0) || (beta2_ff >= ONE_B2);

   always_ff @(posedge clock) begin
      if (en[ST_PREP]) begin
         sqx_ff <= (ONE_B2 - beta2_ff) << SQ_PRE;
      end
   end

   // ---------------------------------------------------------------- item carry
   generate
      for (k = 0; k < ST_OUT; k++) begin : g_base
         item_type src;
         if (k == ST_PRE) begin : g_in
            always_comb begin
               src.px     = req_chan.px_in;
               src.py     = req_chan.py_in;
               src.pz     = req_chan.pz_in;
               src.energy = req_chan.energy_in;
               src.bx     = req_chan.beta_x;
               src.by     = req_chan.beta_y;
               src.bz     = req_chan.beta_z;
               src.pb32   = '0;
               src.pass   = 1'b0;
            end
         end else if (k == ST_SUM) begin : g_pb
            always_comb begin
               src      = base_ff[k-1];
               src.pb32 = pb32_sum;
            end
         end else if (k == ST_PREP) begin : g_pass
            always_comb begin
               src      = base_ff[k-1];
               src.pass = pass_s2;
            end
         end else begin : g_fwd
            assign src = base_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (en[k]) begin
               base_ff[k] <= src;
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------- square root, bit per stage
   logic [33:0] sq_rem_ff  [SQ_STEPS];
   logic [31:0] sq_root_ff [SQ_STEPS];
   logic [63:0] sq_x_ff    [SQ_STEPS];

   generate
      for (k = 0; k < SQ_STEPS; k++) begin : g_sqrt
         logic [33:0] rem_q;
         logic [31:0] root_q;
         logic [63:0] x_q;
         logic [35:0] rem_sh;
         logic [35:0] trial;
         if (k == 0) begin : g_first
            assign rem_q  = '0;
            assign root_q = '0;
            assign x_q    = sqx_ff;
         end else begin : g_next
            assign rem_q  = sq_rem_ff[k-1];
            assign root_q = sq_root_ff[k-1];
            assign x_q    = sq_x_ff[k-1];
         end
         assign rem_sh = {rem_q, x_q[63-2*k -: 2]};
         assign trial  = {2'b00, root_q, 2'b01};
         always_ff @(posedge clock) begin
            if (en[ST_SQ0+k]) begin
               sq_x_ff[k] <= x_q;
               if (rem_sh >= trial) begin
                  sq_rem_ff[k]  <= 34'(rem_sh - trial);
                  sq_root_ff[k] <= {root_q[30:0], 1'b1};
               end else begin
                  sq_rem_ff[k]  <= rem_sh[33:0];
                  sq_root_ff[k] <= {root_q[30:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------- gamma = 2^62 / sq
   logic [31:0]         gd_rem_ff [GD_STEPS];
   logic [31:0]         gd_d_ff   [GD_STEPS];
   logic [GD_STEPS-1:0] gd_q_ff   [GD_STEPS];

   generate
      for (k = 0; k < GD_STEPS; k++) begin : g_gdiv
         logic [31:0]         rem_q;
         logic [31:0]         d_q;
         logic [GD_STEPS-1:0] q_q;
         logic [32:0]         t;
         if (k == 0) begin : g_first
            assign rem_q = GD_REM_INIT;
            assign d_q   = sq_root_ff[SQ_STEPS-1];
            assign q_q   = '0;
         end else begin : g_next
            assign rem_q = gd_rem_ff[k-1];
            assign d_q   = gd_d_ff[k-1];
            assign q_q   = gd_q_ff[k-1];
         end
         assign t = {rem_q, 1'b0};
         always_ff @(posedge clock) begin
            if (en[ST_GD0+k]) begin
               gd_d_ff[k] <= d_q;
               if (t >= {1'b0, d_q}) begin
                  gd_rem_ff[k] <= 32'(t - {1'b0, d_q});
                  gd_q_ff[k]   <= {q_q[GD_STEPS-2:0], 1'b1};
               end else begin
                  gd_rem_ff[k] <= t[31:0];
                  gd_q_ff[k]   <= {q_q[GD_STEPS-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   logic [GD_STEPS-1:0] gx_g_ff;
   logic [61:0]         gx_d_ff;

   always_ff @(posedge clock) begin
      if (en[ST_GX]) begin
         gx_g_ff <= gd_q_ff[GD_STEPS-1];
         gx_d_ff <= 62'(gd_q_ff[GD_STEPS-1]) + 62'(ONE_BETA);
      end
   end

   // ---------------------------------------------------------------- 2^60 / (gamma + 1)
   logic [61:0]         fd_rem_ff [FD_STEPS];
   logic [61:0]         fd_d_ff   [FD_STEPS];
   logic [FD_STEPS-1:0] fd_q_ff   [FD_STEPS];
   logic [GD_STEPS-1:0] fd_g_ff   [FD_STEPS];

   generate
      for (k = 0; k < FD_STEPS; k++) begin : g_fdiv
         logic [61:0]         rem_q;
         logic [61:0]         d_q;
         logic [FD_STEPS-1:0] q_q;
         logic [GD_STEPS-1:0] g_q;
         logic [62:0]         t;
         if (k == 0) begin : g_first
            // divisor is at least 2^31, so the upper quotient bits are zero and 2^30 remains
            assign rem_q = 62'(ONE_BETA);
            assign d_q   = gx_d_ff;
            assign q_q   = '0;
            assign g_q   = gx_g_ff;
         end else begin : g_next
            assign rem_q = fd_rem_ff[k-1];
            assign d_q   = fd_d_ff[k-1];
            assign q_q   = fd_q_ff[k-1];
            assign g_q   = fd_g_ff[k-1];
         end
         assign t = {rem_q, 1'b0};
         always_ff @(posedge clock) begin
            if (en[ST_FD0+k]) begin
               fd_d_ff[k] <= d_q;
               fd_g_ff[k] <= g_q;
               if (t >= {1'b0, d_q}) begin
                  fd_rem_ff[k] <= 62'(t - {1'b0, d_q});
                  fd_q_ff[k]   <= {q_q[FD_STEPS-2:0], 1'b1};
               end else begin
                  fd_rem_ff[k] <= t[61:0];
                  fd_q_ff[k]   <= {q_q[FD_STEPS-2:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------- factor and E*2^16 + pb
   logic [61:0]         fx_f_ff;
   logic [GD_STEPS-1:0] fx_g_ff;
   logic signed [52:0]  fx_s_ff;

   always_ff @(posedge clock) begin
      if (en[ST_FX]) begin
         fx_f_ff <= 62'(fd_g_ff[FD_STEPS-1]) - 62'(ONE_BETA) + 62'(fd_q_ff[FD_STEPS-1]);
         fx_g_ff <= fd_g_ff[FD_STEPS-1];
         fx_s_ff <= (53'(base_ff[ST_FX-1].energy) <<< DATA_FRAC_BITS)
                    + 53'(base_ff[ST_FX-1].pb32);
      end
   end

   // ---------------------------------------------------------------- partial products
   logic signed [63:0] fp_ff [4];
   logic signed [63:0] ge_ff [2];
   logic signed [63:0] gs_ff [4];
   logic [30:0]        f0, g0;
   logic [30:0]        f1;
   logic [29:0]        g1;
   logic [25:0]        q0, q1, s1;
   logic [26:0]        s0;
   data_type           e_m1;

   assign f0   = fx_f_ff[30:0];
   assign f1   = fx_f_ff[61:31];
   assign g0   = fx_g_ff[30:0];
   assign g1   = fx_g_ff[60:31];
   assign q0   = base_ff[ST_M1-1].pb32[25:0];
   assign q1   = base_ff[ST_M1-1].pb32[51:26];
   assign s0   = fx_s_ff[26:0];
   assign s1   = fx_s_ff[52:27];
   assign e_m1 = base_ff[ST_M1-1].energy;

   always_ff @(posedge clock) begin
      if (en[ST_M1]) begin
         fp_ff[0] <= smul(uz33(32'(f0)), uz33(32'(q0)));
         fp_ff[1] <= smul(uz33(32'(f0)), 33'($signed(q1)));
         fp_ff[2] <= smul(uz33(32'(f1)), uz33(32'(q0)));
         fp_ff[3] <= smul(uz33(32'(f1)), 33'($signed(q1)));
         ge_ff[0] <= smul(uz33(32'(g0)), 33'(e_m1));
         ge_ff[1] <= smul(uz33(32'(g1)), 33'(e_m1));
         gs_ff[0] <= smul(uz33(32'(g0)), uz33(32'(s0)));
         gs_ff[1] <= smul(uz33(32'(g0)), 33'($signed(s1)));
         gs_ff[2] <= smul(uz33(32'(g1)), uz33(32'(s0)));
         gs_ff[3] <= smul(uz33(32'(g1)), 33'($signed(s1)));
      end
   end

   logic signed [89:0] fa_ff, fb_ff, gsa_ff, gsb_ff;
   logic signed [95:0] gef_ff;

   always_ff @(posedge clock) begin
      if (en[ST_M2]) begin
         fa_ff  <= 90'(fp_ff[0]) + (90'(fp_ff[1]) <<< 26);
         fb_ff  <= 90'(fp_ff[2]) + (90'(fp_ff[3]) <<< 26);
         gef_ff <= 96'(ge_ff[0]) + (96'(ge_ff[1]) <<< 31);
         gsa_ff <= 90'(gs_ff[0]) + (90'(gs_ff[1]) <<< 27);
         gsb_ff <= 90'(gs_ff[2]) + (90'(gs_ff[3]) <<< 27);
      end
   end

   logic signed [115:0] fpb_ff, gek_ff, gsf_ff;

   always_ff @(posedge clock) begin
      if (en[ST_M3]) begin
         fpb_ff <= 116'(fa_ff) + (116'(fb_ff) <<< 31);
         gek_ff <= 116'(gef_ff) <<< DATA_FRAC_BITS;
         gsf_ff <= 116'(gsa_ff) + (116'(gsb_ff) <<< 31);
      end
   end

   // ---------------------------------------------------------------- k and boosted energy
   logic signed [115:0] k_ff;
   logic [32:0]         eo_ff [4];
   logic [32:0]         e_clamp;

   assign e_clamp = clamp32(128'(gsf_ff >>> K_SHIFT));

   always_ff @(posedge clock) begin
      if (en[ST_M4]) begin
         k_ff     <= fpb_ff + gek_ff;
         eo_ff[0] <= e_clamp;
      end
   end

   logic signed [115:0] k_sh;
   logic signed [63:0]  k16_ff;

   assign k_sh = k_ff >>> K_SHIFT;

   always_ff @(posedge clock) begin
      if (en[ST_M5]) begin
         eo_ff[1] <= eo_ff[0];
         if (k_sh > K_HI) begin
            k16_ff <= 64'(K_HI);
         end else if (k_sh < K_LO) begin
            k16_ff <= 64'(K_LO);
         end else begin
            k16_ff <= 64'(k_sh);
         end
      end
   end

   logic signed [63:0] bl_ff [3];
   logic signed [63:0] bh_ff [3];
   data_type           b_m6 [3];

   assign b_m6[0] = base_ff[ST_M6-1].bx;
   assign b_m6[1] = base_ff[ST_M6-1].by;
   assign b_m6[2] = base_ff[ST_M6-1].bz;

   always_ff @(posedge clock) begin
      if (en[ST_M6]) begin
         eo_ff[2] <= eo_ff[1];
         for (int i = 0; i < 3; i++) begin
            bl_ff[i] <= smul(33'(b_m6[i]), uz33(k16_ff[31:0]));
            bh_ff[i] <= smul(33'(b_m6[i]), 33'($signed(k16_ff[63:32])));
         end
      end
   end

   logic signed [96:0] t_ff [3];
   data_type           p_m7 [3];

   assign p_m7[0] = base_ff[ST_M7-1].px;
   assign p_m7[1] = base_ff[ST_M7-1].py;
   assign p_m7[2] = base_ff[ST_M7-1].pz;

   always_ff @(posedge clock) begin
      if (en[ST_M7]) begin
         eo_ff[3] <= eo_ff[2];
         for (int i = 0; i < 3; i++) begin
            t_ff[i] <= (97'(p_m7[i]) <<< BETA_FRAC_BITS) + (97'(bh_ff[i]) <<< 32)
                       + 97'(bl_ff[i]);
         end
      end
   end

   // ---------------------------------------------------------------- output register
   res_type     res_in, res_ff;
   item_type    it_out;
   logic [32:0] pc [3];

   assign it_out = base_ff[ST_OUT-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pc[i] = clamp32(128'(t_ff[i] >>> BETA_FRAC_BITS));
      end
      if (it_out.pass) begin
         res_in.px     = it_out.px;
         res_in.py     = it_out.py;
         res_in.pz     = it_out.pz;
         res_in.energy = it_out.energy;
         res_in.pass   = 1'b1;
         res_in.sat    = 1'b0;
      end else begin
         res_in.px     = pc[0][31:0];
         res_in.py     = pc[1][31:0];
         res_in.pz     = pc[2][31:0];
         res_in.energy = eo_ff[3][31:0];
         res_in.pass   = 1'b0;
         res_in.sat    = pc[0][32] | pc[1][32] | pc[2][32] | eo_ff[3][32];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid          = v_ff[NST-1];
   assign rsp_chan.px_out         = res_ff.px;
   assign rsp_chan.py_out         = res_ff.py;
   assign rsp_chan.pz_out         = res_ff.pz;
   assign rsp_chan.energy_out     = res_ff.energy;
   assign rsp_chan.passed_through = res_ff.pass;
   assign rsp_chan.saturated      = res_ff.sat;

endmodule

// File: tb/sv/lbfv_boost_checker.sv
// lbfv_boost_checker: watches the req and rsp channels, predicts each boosted four-vector
// and compares it with what the core returns; depends on lbfv_pkg and the channel interfaces
`timescale 1ns / 100ps
module lbfv_boost_checker import lbfv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lbfv_req_if.sink  req_mon,
   lbfv_rsp_if.sink  rsp_mon,
   output int        fail_count,
   output int        pending_count
);

   typedef struct {
      logic signed [31:0] px, py, pz, en;
      logic               pass, sat;
   } boosted_type;

   boosted_type boosted_q[$];

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // clip a wide signed value into [lo, hi]
   function automatic logic signed [159:0] clip(logic signed [159:0] v,
         logic signed [159:0] lo, logic signed [159:0] hi, inout logic hit);
      if (v < lo) begin hit = 1; return lo; end
      if (v > hi) begin hit = 1; return hi; end
      return v;
   endfunction

   function automatic boosted_type boost(data_type px, data_type py, data_type pz,
                                         data_type en, data_type bx, data_type by,
                                         data_type bz);
      boosted_type r;
      logic [63:0] b2, sq, gam, fac;
      logic signed [159:0] p [3], b [3], pb, pb32, k, k16, t, s, lo32, hi32, lim;
      logic dummy;
      p[0] = px; p[1] = py; p[2] = pz;
      b[0] = bx; b[1] = by; b[2] = bz;
      b2 = 0;
      for (int i = 0; i < 3; i++) b2 = b2 + 64'(b[i] * b[i]);
      r.pass = 0; r.sat = 0;
      if (b2 == 0 || b2 >= ONE_B2) begin
         r.px = px; r.py = py; r.pz = pz; r.en = en; r.pass = 1;
         return r;
      end
      sq = root_floor((ONE_B2 - b2) << SQ_PRE);
      gam = (64'd1 << 62) / sq;
      fac = gam - ONE_BETA + ONE_B2 / (gam + ONE_BETA);
      pb = 0;
      for (int i = 0; i < 3; i++) pb = pb + p[i] * b[i];
      pb32 = pb >>> PB_SHIFT;
      k = $signed({96'd0, fac}) * pb32 + (($signed({96'd0, gam}) * $signed(160'(en)))
          <<< DATA_FRAC_BITS);
      lim = 160'sd1 <<< 62;
      dummy = 0;
      k16 = clip(k >>> K_SHIFT, -lim, lim, dummy);
      lo32 = -(160'sd1 <<< 31);
      hi32 = (160'sd1 <<< 31) - 1;
      for (int i = 0; i < 3; i++) begin
         t = clip(((p[i] <<< BETA_FRAC_BITS) + b[i] * k16) >>> BETA_FRAC_BITS, lo32, hi32,
                  r.sat);
         if (i == 0) r.px = t[31:0];
         else if (i == 1) r.py = t[31:0];
         else r.pz = t[31:0];
      end
      s = (p[0] * 0 + $signed(160'(en))) * 65536 + pb32;
      t = clip(($signed({96'd0, gam}) * s) >>> K_SHIFT, lo32, hi32, r.sat);
      r.en = t[31:0];
      return r;
   endfunction

   assign pending_count = boosted_q.size();

   always @(posedge clock) begin
      boosted_type e;
      if (reset) begin
         boosted_q.delete();
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            boosted_q.push_back(boost(req_mon.px_in, req_mon.py_in, req_mon.pz_in,
                                      req_mon.energy_in, req_mon.beta_x, req_mon.beta_y,
                                      req_mon.beta_z));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (boosted_q.size() == 0) begin
               $error("result transfer with nothing outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = boosted_q.pop_front();
               if (e.px !== rsp_mon.px_out || e.py !== rsp_mon.py_out ||
                   e.pz !== rsp_mon.pz_out || e.en !== rsp_mon.energy_out ||
                   e.pass !== rsp_mon.passed_through || e.sat !== rsp_mon.saturated) begin
                  if (e.px !== rsp_mon.px_out)
                     $error("px_out expected %0d got %0d", e.px, rsp_mon.px_out);
                  if (e.py !== rsp_mon.py_out)
                     $error("py_out expected %0d got %0d", e.py, rsp_mon.py_out);
                  if (e.pz !== rsp_mon.pz_out)
                     $error("pz_out expected %0d got %0d", e.pz, rsp_mon.pz_out);
                  if (e.en !== rsp_mon.energy_out)
                     $error("energy_out expected %0d got %0d", e.en, rsp_mon.energy_out);
                  if (e.pass !== rsp_mon.passed_through)
                     $error("passed_through expected %0b got %0b", e.pass,
                            rsp_mon.passed_through);
                  if (e.sat !== rsp_mon.saturated)
                     $error("saturated expected %0b got %0b", e.sat, rsp_mon.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: tb/sv/tb_lorentz_boost_four_vector_core.sv
// tb_lorentz_boost_four_vector_core: drives four-vectors with boosts into the core and
// gives the verdict; depends on lbfv_pkg, the channel interfaces and lbfv_boost_checker
`timescale 1ns / 100ps
module tb_lorentz_boost_four_vector_core import lbfv_pkg::*; ();

   localparam int N_RANDOM = 1630;
   localparam int STALL_LIMIT = 20000;

   logic clock, reset;
   int   fail_count, pending_count, idle_cycles, sent, n_pass;
   bit   calm;

   lbfv_req_if req_chan ();
   lbfv_rsp_if rsp_chan ();

   lorentz_boost_four_vector_core i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   lbfv_boost_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      clock = 1; #5;
      clock = 0; #5;
   end

   // result side stalls at random, except during the calm stretch
   always @(negedge clock)
      rsp_chan.ready <= calm || ($urandom_range(99) >= 38);

   always @(posedge clock)
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;

   always @(posedge clock)
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end

   function automatic data_type rand_beta(int mode);
      case (mode)
         0: return $urandom_range(32'h4000_0000);
         1: return -$signed(32'($urandom_range(32'h4000_0000)));
         2: return $signed(32'($urandom_range(32'h0100_0000))) - 32'sh0080_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_boost(data_type px, data_type py, data_type pz, data_type en,
                             data_type bx, data_type by, data_type bz);
      while (!calm && $urandom_range(99) < 38) begin
         req_chan.valid <= 0;
         @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.px_in <= px; req_chan.py_in <= py; req_chan.pz_in <= pz;
      req_chan.energy_in <= en;
      req_chan.beta_x <= bx; req_chan.beta_y <= by; req_chan.beta_z <= bz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (bx == 0 && by == 0 && bz == 0) n_pass++;
      sent++;
      @(negedge clock);
   endtask

   initial begin
      data_type small_v, b0, b1, b2;
      req_chan.valid = 0;
      req_chan.px_in = 0; req_chan.py_in = 0; req_chan.pz_in = 0; req_chan.energy_in = 0;
      req_chan.beta_x = 0; req_chan.beta_y = 0; req_chan.beta_z = 0;
      calm = 0; sent = 0; n_pass = 0;
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: zero boost, beta at one and past it, extremes, tiny and near-light boosts
      send_boost(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h000a_0000, 0, 0, 0);
      send_boost(32'h7fff_ffff, 32'h8000_0000, -1, 32'h7fff_ffff, 32'h4000_0000, 0, 0);
      send_boost(5, 6, 7, 8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_boost(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h3fff_ffff, 0, 0);
      send_boost(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h2000_0000, 32'h2000_0000, 32'h2000_0000);
      send_boost(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'hc000_0000, 0, 32'h1000_0000);
      send_boost(32'h0001_0000, 0, 0, 32'h0002_0000, 1, 0, 0);
      send_boost(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 32'h3fff_f000, 0);
      send_boost(0, 0, -32'sh0001_0000, 32'h0001_0000, 0, 0, 32'hc000_1000);
      send_boost(32'h0010_0000, 32'hfff0_0000, 32'h0001_8000, 32'h0020_0000,
                 32'h1000_0000, 32'hf000_0000, 32'h0800_0000);
      send_boost(-1, -1, -1, -1, -1, -1, -1);
      send_boost(0, 0, 0, 0, 32'h2d41_3ccc, 32'h2d41_3ccc, 0);
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 600 && i < 800);
         small_v = $signed(32'($urandom_range(32'h00ff_ffff))) - 32'sh0080_0000;
         b0 = rand_beta($urandom_range(3)); b1 = rand_beta($urandom_range(3));
         b2 = rand_beta($urandom_range(3));
         // keep most boosts subluminal so the datapath is exercised
         if ($urandom_range(9) < 6) begin b0 = b0 >>> 1; b1 = b1 >>> 1; b2 = b2 >>> 1; end
         if ($urandom_range(19) == 0) begin b0 = 0; b1 = 0; b2 = 0; end
         if ($urandom_range(3) == 0)
            send_boost($urandom, $urandom, $urandom, $urandom, b0, b1, b2);
         else
            send_boost(small_v, small_v + $urandom_range(4096), $urandom_range(65535),
                       $urandom_range(32'h00ff_ffff), b0, b1, b2);
      end
      calm = 0;
      req_chan.valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("sent %0d four-vectors, %0d with zero boost, random signs and magnitudes",
               sent, n_pass);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
